@@ hw/rtl/toy_cpu_execute_with_segment_check_core_assert.svh @@
// Assertion helpers for the toy CPU execute core.
// Both checks are sampled on the rising clock edge and are off while reset is low.
`ifndef TOY_CPU_EXECUTE_WITH_SEGMENT_CHECK_CORE_ASSERT_SVH
`define TOY_CPU_EXECUTE_WITH_SEGMENT_CHECK_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TOYCPU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TOYCPU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/toycpu_pkg.sv @@
`default_nettype none

package toycpu_pkg;

    localparam int DATA_W    = 32;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = $clog2(NUM_REGS);

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 136;

    typedef enum logic [3:0] {
        OP_SET       = 4'd0,
        OP_SUM       = 4'd1,
        OP_SUB       = 4'd2,
        OP_READ      = 4'd3,
        OP_WRITE     = 4'd4,
        OP_JNZ       = 4'd5,
        OP_LOG       = 4'd6,
        OP_SYSCALL   = 4'd7,
        OP_MEM_RESP  = 4'd8,
        OP_RAISE     = 4'd9,
        OP_CHECK_INT = 4'd10
    } t_op;

    typedef enum logic [1:0] {
        REQ_NONE  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2
    } t_req;

    typedef enum logic {
        CFG_BASE  = 1'b0,
        CFG_LIMIT = 1'b1
    } t_cfg_idx;

    localparam logic [3:0] CODE_SEGFAULT = 4'd0;
    localparam logic [1:0] PRIO_SEGFAULT = 2'd1;
    localparam logic [1:0] PRIO_SYSCALL  = 2'd2;

    typedef struct packed {
        t_op         op;
        logic [3:0]  reg_first;
        logic [3:0]  reg_second;
        logic [31:0] immediate;
        logic [31:0] mem_data;
        logic        mem_status;
        logic [3:0]  event_code;
        logic [1:0]  event_priority;
    } t_item;

    typedef struct packed {
        logic [31:0] program_counter;
        t_req        mem_request;
        logic [31:0] mem_address;
        logic [31:0] mem_write_value;
        logic [31:0] log_value;
        logic        operand_error;
        logic        interrupt_valid;
        logic [3:0]  interrupt_code;
        logic [1:0]  interrupt_priority;
    } t_result;

    typedef struct packed {
        logic [31:0]          pc;
        logic [REG_IDX_W-1:0] rd_dest;
        logic                 rd_outstanding;
        logic                 pend_valid;
        logic [3:0]           pend_code;
        logic [1:0]           pend_prio;
    } t_arch_state;

    typedef struct packed {
        logic                 wen;
        logic [REG_IDX_W-1:0] waddr;
        logic [DATA_W-1:0]    wdata;
    } t_rf_write;

endpackage

`default_nettype wire

@@ hw/rtl/toycpu_exec.sv @@
`default_nettype none

// Executes one item against the architectural state: produces the result,
// the next state and at most one register file write.
module toycpu_exec
    import toycpu_pkg::*;
(
    input  var t_item             i_item,
    input  var logic [DATA_W-1:0] i_opnd_a,
    input  var logic [DATA_W-1:0] i_opnd_b,
    input  var t_arch_state       i_state,
    input  var logic [31:0]       i_seg_base,
    input  var logic [31:0]       i_seg_limit,
    output t_result               o_result,
    output t_arch_state           o_next_state,
    output t_rf_write             o_rf_write
);

    logic       ok_a;
    logic       ok_b;
    logic       step;
    logic       raise;
    logic [3:0] raise_code;
    logic [1:0] raise_prio;

    assign ok_a = 32'(i_item.reg_first) < NUM_REGS;
    assign ok_b = 32'(i_item.reg_second) < NUM_REGS;

    always_comb begin
        o_result     = '0;
        o_next_state = i_state;
        o_rf_write   = '0;
        step         = 1'b0;
        raise        = 1'b0;
        raise_code   = CODE_SEGFAULT;
        raise_prio   = PRIO_SEGFAULT;

        o_rf_write.waddr = i_item.reg_first[REG_IDX_W-1:0];

        case (i_item.op)
            OP_SET: begin
                step = 1'b1;
                if (ok_a) begin
                    o_rf_write.wen   = 1'b1;
                    o_rf_write.wdata = i_item.immediate;
                end else begin
                    o_result.operand_error = 1'b1;
                end
            end
            OP_SUM, OP_SUB: begin
                step = 1'b1;
                if (ok_a && ok_b) begin
                    o_rf_write.wen   = 1'b1;
                    o_rf_write.wdata = (i_item.op == OP_SUM) ? i_opnd_a + i_opnd_b
                                                             : i_opnd_a - i_opnd_b;
                end else begin
                    o_result.operand_error = 1'b1;
                end
            end
            OP_READ: begin
                step = 1'b1;
                if (!(ok_a && ok_b)) begin
                    o_result.operand_error = 1'b1;
                end else if (i_opnd_b >= i_seg_limit) begin
                    raise = 1'b1;
                end else begin
                    o_result.mem_request        = REQ_READ;
                    o_result.mem_address        = i_seg_base + i_opnd_b;
                    o_next_state.rd_dest        = i_item.reg_first[REG_IDX_W-1:0];
                    o_next_state.rd_outstanding = 1'b1;
                end
            end
            OP_WRITE: begin
                step = 1'b1;
                if (!(ok_a && ok_b)) begin
                    o_result.operand_error = 1'b1;
                end else if (i_opnd_a >= i_seg_limit) begin
                    raise = 1'b1;
                end else begin
                    o_result.mem_request     = REQ_WRITE;
                    o_result.mem_address     = i_seg_base + i_opnd_a;
                    o_result.mem_write_value = i_opnd_b;
                end
            end
            OP_JNZ: begin
                if (!ok_a) begin
                    o_result.operand_error = 1'b1;
                end else if (i_opnd_a != '0) begin
                    o_next_state.pc = i_item.immediate;
                end else begin
                    step = 1'b1;
                end
            end
            OP_LOG: begin
                step = 1'b1;
                if (ok_a) begin
                    o_result.log_value = i_opnd_a;
                end else begin
                    o_result.operand_error = 1'b1;
                end
            end
            OP_SYSCALL: begin
                step       = 1'b1;
                raise      = 1'b1;
                raise_code = i_item.event_code;
                raise_prio = PRIO_SYSCALL;
            end
            OP_MEM_RESP: begin
                if (i_item.mem_status) begin
                    raise = 1'b1;
                end else if (i_state.rd_outstanding) begin
                    o_rf_write.wen   = 1'b1;
                    o_rf_write.waddr = i_state.rd_dest;
                    o_rf_write.wdata = i_item.mem_data;
                end
                o_next_state.rd_outstanding = 1'b0;
            end
            OP_RAISE: begin
                raise      = 1'b1;
                raise_code = i_item.event_code;
                raise_prio = i_item.event_priority;
            end
            OP_CHECK_INT: begin
                if (i_state.pend_valid) begin
                    o_result.interrupt_valid    = 1'b1;
                    o_result.interrupt_code     = i_state.pend_code;
                    o_result.interrupt_priority = i_state.pend_prio;
                end
                o_next_state.pend_valid = 1'b0;
                o_next_state.pend_code  = '0;
                o_next_state.pend_prio  = '0;
            end
            default: begin
            end
        endcase

        // Only a strictly more urgent interrupt displaces the one already held.
        if (raise && (!i_state.pend_valid || raise_prio < i_state.pend_prio)) begin
            o_next_state.pend_valid = 1'b1;
            o_next_state.pend_code  = raise_code;
            o_next_state.pend_prio  = raise_prio;
        end

        if (step) begin
            o_next_state.pc = i_state.pc + 32'd1;
        end

        o_result.program_counter = o_next_state.pc;
    end

endmodule

`default_nettype wire

@@ hw/rtl/toy_cpu_execute_with_segment_check_core.sv @@
// Channel   Direction  Handshake                 Payload
// s         in         i_s_tvalid / o_s_tready   i_s_tdata (80), i_s_tuser (4)
// m         out        o_m_tvalid / i_m_tready   o_m_tdata (136), o_m_tuser (2)
// cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index (1), i_cfg_data (32)
//
// Every item yields exactly one result item, via the input stage and result register.
// One item is accepted per cycle unless the output stalls: the register file read for
// an item happens as it is taken in, and a write made by the item ahead of it is forwarded.
// Reset (synchronous, active low) clears the pipeline, PC, interrupt slot,
// segment registers and register file valid bits; no clearing pass is needed.
// A stalled output holds its result while one more item waits in the input stage.
`default_nettype none

`include "toy_cpu_execute_with_segment_check_core_assert.svh"

module toy_cpu_execute_with_segment_check_core
    import toycpu_pkg::*;
(
    input  var logic                   i_clk,
    input  var logic                   i_rst_n,

    input  var logic                   i_s_tvalid,
    output logic                       o_s_tready,
    // reg_first[3:0], reg_second[7:4], immediate[39:8], mem_data[71:40],
    // mem_status[72], event_code[76:73], event_priority[78:77], zero[79]
    input  var logic [IN_TDATA_W-1:0]  i_s_tdata,
    // operation[3:0]
    input  var logic [3:0]             i_s_tuser,

    output logic                       o_m_tvalid,
    input  var logic                   i_m_tready,
    // program_counter[31:0], mem_address[63:32], mem_write_value[95:64],
    // log_value[127:96], operand_error[128], interrupt_valid[129],
    // interrupt_code[133:130], interrupt_priority[135:134]
    output logic [OUT_TDATA_W-1:0]     o_m_tdata,
    // mem_request[1:0]
    output logic [1:0]                 o_m_tuser,

    input  var logic                   i_cfg_valid,
    output logic                       o_cfg_ready,
    input  var logic                   i_cfg_index,
    input  var logic [31:0]            i_cfg_data
);

    // Input stage: the item plus its register operands, read as it arrives.
    logic              r_in_valid;
    t_item             r_in;
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;
    logic              r_a_vld;
    logic              r_b_vld;
    logic              r_a_byp;
    logic              r_b_byp;
    logic [DATA_W-1:0] r_byp_data;

    // Architectural state, segment registers and the result register.
    t_arch_state       r_state;
    logic [31:0]       r_seg_base;
    logic [31:0]       r_seg_limit;
    logic              r_out_valid;
    t_result           r_out;

    // Register file storage and its per-entry valid bits; an entry never
    // written since reset reads as zero.
    logic [DATA_W-1:0]   mem_rf [NUM_REGS];
    logic [NUM_REGS-1:0] r_rf_vld;

    t_item             in_item;
    logic              in_fire;
    logic              exec_fire;
    logic              rf_wen;
    logic [DATA_W-1:0] opnd_a;
    logic [DATA_W-1:0] opnd_b;
    t_result           exec_result;
    t_arch_state       n_state;
    t_rf_write         exec_write;
    logic [REG_IDX_W-1:0] idx_a;
    logic [REG_IDX_W-1:0] idx_b;

    assign in_item.op             = t_op'(i_s_tuser);
    assign in_item.reg_first      = i_s_tdata[3:0];
    assign in_item.reg_second     = i_s_tdata[7:4];
    assign in_item.immediate      = i_s_tdata[39:8];
    assign in_item.mem_data       = i_s_tdata[71:40];
    assign in_item.mem_status     = i_s_tdata[72];
    assign in_item.event_code     = i_s_tdata[76:73];
    assign in_item.event_priority = i_s_tdata[78:77];

    assign idx_a = in_item.reg_first[REG_IDX_W-1:0];
    assign idx_b = in_item.reg_second[REG_IDX_W-1:0];

    // The execute step fires when the result register is free or being emptied;
    // the input stage refills in the same cycle.
    assign exec_fire  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || exec_fire;
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign rf_wen     = exec_fire && exec_write.wen;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_base  <= '0;
            r_seg_limit <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BASE:  r_seg_base  <= i_cfg_data;
                CFG_LIMIT: r_seg_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (rf_wen) begin
            mem_rf[exec_write.waddr] <= exec_write.wdata;
        end
        if (in_fire) begin
            r_rd_a <= mem_rf[idx_a];
            r_rd_b <= mem_rf[idx_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (rf_wen) begin
            r_rf_vld[exec_write.waddr] <= 1'b1;
        end
    end

    // Operand capture: a write landing in the same cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in       <= in_item;
            r_a_vld    <= r_rf_vld[idx_a];
            r_b_vld    <= r_rf_vld[idx_b];
            r_a_byp    <= rf_wen && (exec_write.waddr == idx_a);
            r_b_byp    <= rf_wen && (exec_write.waddr == idx_b);
            r_byp_data <= exec_write.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    assign opnd_a = r_a_byp ? r_byp_data : (r_a_vld ? r_rd_a : '0);
    assign opnd_b = r_b_byp ? r_byp_data : (r_b_vld ? r_rd_b : '0);

    toycpu_exec u_exec (
        .i_item       (r_in),
        .i_opnd_a     (opnd_a),
        .i_opnd_b     (opnd_b),
        .i_state      (r_state),
        .i_seg_base   (r_seg_base),
        .i_seg_limit  (r_seg_limit),
        .o_result     (exec_result),
        .o_next_state (n_state),
        .o_rf_write   (exec_write)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (exec_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out <= exec_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.mem_request;
    assign o_m_tdata  = {r_out.interrupt_priority, r_out.interrupt_code,
                         r_out.interrupt_valid, r_out.operand_error,
                         r_out.log_value, r_out.mem_write_value,
                         r_out.mem_address, r_out.program_counter};

    // A request never goes out together with an operand error.
    `TOYCPU_ASSERT_NOW(a_req_no_err, i_clk, i_rst_n,
        r_out_valid && (r_out.mem_request != REQ_NONE), !r_out.operand_error,
        "memory request issued with an operand error")

    // An issued read leaves a read outstanding.
    `TOYCPU_ASSERT_NEXT(a_read_outstanding, i_clk, i_rst_n,
        exec_fire && (exec_result.mem_request == REQ_READ), r_state.rd_outstanding,
        "read issued but no read outstanding")

    // Checking the interrupt slot always empties it.
    `TOYCPU_ASSERT_NEXT(a_check_clears, i_clk, i_rst_n,
        exec_fire && (r_in.op == OP_CHECK_INT), !r_state.pend_valid,
        "interrupt slot not cleared by a check")

    // A check on a full slot hands out an interrupt in the next result.
    `TOYCPU_ASSERT_NEXT(a_check_hands_out, i_clk, i_rst_n,
        exec_fire && (r_in.op == OP_CHECK_INT) && r_state.pend_valid,
        r_out_valid && r_out.interrupt_valid,
        "pending interrupt not handed out")

endmodule

`default_nettype wire
